>>> rtl/core/cepc_pkg.sv
// Shared types and constants for the core event priority controller.
`timescale 1ns / 1ps
package cepc_pkg;

  localparam int NUM_LEVELS = 16;
  localparam int LVL_W      = 4;
  localparam int CUR_W      = 5;
  localparam int PC_W       = 32;
  localparam int NUM_RA     = 4;
  localparam int CFG_W      = 9;

  typedef logic [NUM_LEVELS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_RAISE  = 3'd0,
    OP_RETURN = 3'd1,
    OP_MCLR   = 3'd2,
    OP_MSET   = 3'd3,
    OP_GEN    = 3'd4,
    OP_GDIS   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_VECTOR = 2'd1,
    RD_RETURN = 2'd2
  } redirect_e;

  typedef enum logic [1:0] {
    FLT_NONE   = 2'd0,
    FLT_PRIV   = 2'd1,
    FLT_DOUBLE = 2'd2,
    FLT_EMU    = 2'd3
  } fault_e;

  typedef enum logic {
    CFG_SELF_NEST = 1'b0,
    CFG_RESET_VEC = 1'b1
  } cfg_idx_e;

  // fixed levels
  localparam logic [LVL_W-1:0] LVL_EMU  = 4'd0;
  localparam logic [LVL_W-1:0] LVL_RST  = 4'd1;
  localparam logic [LVL_W-1:0] LVL_NMI  = 4'd2;
  localparam logic [LVL_W-1:0] LVL_EVX  = 4'd3;
  localparam logic [LVL_W-1:0] LVL_GDIS = 4'd4;
  localparam logic [CUR_W-1:0] LVL_USER = CUR_W'(NUM_LEVELS);

  // return address slots
  localparam logic [1:0] RA_EMU = 2'd0;
  localparam logic [1:0] RA_NMI = 2'd1;
  localparam logic [1:0] RA_EVX = 2'd2;
  localparam logic [1:0] RA_INT = 2'd3;

  localparam word_t UNMASKABLE  = 16'h001f;
  localparam word_t MASK_RESET  = 16'h001f;
  localparam word_t PEND_RESET  = 16'h0012;
  localparam logic [CFG_W-1:0] OVERRIDE_BITS = 9'h1ff;

  typedef struct packed {
    op_e               op;
    logic [LVL_W-1:0]  level;
    logic              use_current;
    logic [15:0]       mask_value;
    logic [PC_W-1:0]   pc;
  } evt_t;

  typedef struct packed {
    redirect_e         redirect;
    logic [LVL_W-1:0]  vector_level;
    logic              use_reset_vector;
    logic [PC_W-1:0]   target_pc;
    logic [15:0]       prior_mask;
    fault_e            fault;
    logic [CUR_W-1:0]  current_level;
    logic              supervisor;
  } res_t;

  typedef struct packed {
    word_t                       mask;
    word_t                       pend;
    word_t                       latch;
    logic [NUM_RA-1:0][PC_W-1:0] ra;
  } state_t;

endpackage

>>> rtl/core/cepc_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps
interface cepc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/cepc_engine.sv
// Combinational event evaluation: next controller state and result for one beat.
`timescale 1ns / 1ps
module cepc_engine (
  input  cepc_pkg::state_t             state_i,
  input  logic                         snen_i,
  input  logic [cepc_pkg::CFG_W-1:0]   rvo_i,
  input  cepc_pkg::evt_t               item_i,
  output cepc_pkg::state_t             state_o,
  output cepc_pkg::res_t               res_o
);
  import cepc_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [LVL_W-1:0] idx;
  } find_t;

  function automatic find_t lowest_bit(input word_t w);
    find_t r;
    r = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.hit = 1'b1;
        r.idx = LVL_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [CUR_W-1:0] active_level(input word_t pend);
    find_t f;
    word_t m;
    m = '0;
    m[LVL_GDIS] = 1'b1;
    f = lowest_bit(pend & ~m);
    return f.hit ? {1'b0, f.idx} : LVL_USER;
  endfunction

  function automatic logic in_user(input word_t pend);
    word_t m;
    m = '0;
    m[LVL_GDIS] = 1'b1;
    m[LVL_EMU]  = 1'b1;
    return (pend & ~m) == '0;
  endfunction

  state_t            st;
  res_t              res;
  logic              rq;
  logic              rq_chk;
  logic [LVL_W-1:0]  rq_lvl;
  logic [PC_W-1:0]   rq_pc;
  logic              pfault;
  logic              emu_was;
  logic              ok;
  logic [1:0]        slot;
  logic [LVL_W-1:0]  rev;
  logic [CUR_W-1:0]  cur;
  logic [PC_W-1:0]   tgt;
  logic              gdis;
  logic              go;
  logic              enter;
  logic [LVL_W-1:0]  ev;
  logic [CUR_W-1:0]  ev5;
  find_t             hit;
  word_t             rvo_ext;

  always_comb begin
    st      = state_i;
    res     = '0;
    rq      = 1'b0;
    rq_chk  = 1'b0;
    rq_lvl  = item_i.level;
    rq_pc   = item_i.pc;
    pfault  = 1'b0;
    emu_was = 1'b0;
    ok      = 1'b0;
    slot    = RA_INT;
    rev     = '0;
    cur     = '0;
    tgt     = '0;
    gdis    = 1'b0;
    go      = 1'b0;
    enter   = 1'b0;
    ev      = '0;
    ev5     = '0;
    hit     = '0;
    rvo_ext = word_t'(rvo_i);

    unique case (item_i.op)
      OP_RAISE: begin
        if (in_user(st.pend)) begin
          pfault = 1'b1;
        end else begin
          rq     = 1'b1;
          rq_chk = item_i.use_current;
        end
      end
      OP_RETURN: begin
        // explicit return from the global-disable level is ignored
        if (item_i.use_current || item_i.level != LVL_GDIS) begin
          emu_was = st.pend[LVL_EMU];
          st.pend[LVL_EMU] = 1'b0;
          if (in_user(st.pend)) begin
            pfault = 1'b1;
          end else begin
            cur = active_level(st.pend);
            rev = item_i.use_current ? cur[LVL_W-1:0] : item_i.level;
            unique case (rev)
              LVL_EMU: begin ok = emu_was;                   slot = RA_EMU; end
              LVL_NMI: begin ok = (cur == {1'b0, LVL_NMI}); slot = RA_NMI; end
              LVL_EVX: begin ok = (cur == {1'b0, LVL_EVX}); slot = RA_EVX; end
              default: begin
                ok   = !(cur < 5'd5 && cur != {1'b0, LVL_RST});
                slot = RA_INT;
              end
            endcase
            if (!ok) begin
              pfault = 1'b1;
            end else begin
              tgt = st.ra[slot];
              // bit 0 marks a self-nested entry: keep the level pending
              if (tgt[0]) tgt[0] = 1'b0;
              else        st.pend[rev] = 1'b0;
              res.target_pc      = tgt;
              res.redirect       = RD_RETURN;
              st.pend[LVL_GDIS]  = 1'b0;
              rq     = 1'b1;
              rq_chk = 1'b1;
              rq_pc  = tgt;
            end
          end
        end
      end
      OP_MCLR: begin
        if (in_user(st.pend)) begin
          pfault = 1'b1;
        end else begin
          res.prior_mask = st.mask;
          st.mask        = st.mask & UNMASKABLE;
        end
      end
      OP_MSET: begin
        if (in_user(st.pend)) begin
          pfault = 1'b1;
        end else begin
          st.mask = (item_i.mask_value & ~UNMASKABLE) | (st.mask & UNMASKABLE);
        end
      end
      OP_GEN: begin
        st.pend[LVL_GDIS] = 1'b0;
        rq     = 1'b1;
        rq_chk = 1'b1;
      end
      OP_GDIS: begin
        st.pend[LVL_GDIS] = 1'b1;
      end
      default: begin
      end
    endcase

    // privilege violation turns into an exception raise
    if (pfault) begin
      res.fault = FLT_PRIV;
      rq        = 1'b1;
      rq_chk    = 1'b0;
      rq_lvl    = LVL_EVX;
      rq_pc     = item_i.pc;
    end

    if (rq) begin
      cur  = active_level(st.pend);
      gdis = st.pend[LVL_GDIS];
      go   = 1'b1;
      ev   = rq_lvl;
      if (rq_chk) begin
        hit = lowest_bit(st.latch);
        ev  = hit.idx;
        if (gdis || !hit.hit || {1'b0, hit.idx} > cur ||
            (!snen_i && {1'b0, hit.idx} == cur)) begin
          go = 1'b0;
        end
      end
      ev5 = {1'b0, ev};
      if (go) begin
        st.latch[ev] = 1'b1;
        if (ev == LVL_EMU || ev == LVL_RST) begin
          enter = 1'b1;
        end else if (ev5 <= {1'b0, LVL_EVX} && cur <= {1'b0, LVL_EVX} && ev5 >= cur) begin
          res.fault = FLT_DOUBLE;
        end else if (gdis && cur != LVL_USER) begin
          enter = 1'b0;
        end else if (!st.mask[ev]) begin
          enter = 1'b0;
        end else if (ev5 < cur || (snen_i && ev5 == cur)) begin
          enter = 1'b1;
        end
      end
      if (enter) begin
        st.pend[ev]  = 1'b1;
        st.latch[ev] = 1'b0;
        case (ev)
          LVL_EMU: begin
            st.ra[RA_EMU] = rq_pc;
            res.fault     = FLT_EMU;
          end
          LVL_NMI: st.ra[RA_NMI] = rq_pc;
          LVL_EVX: st.ra[RA_EVX] = rq_pc;
          LVL_RST, LVL_GDIS: begin
          end
          default: st.ra[RA_INT] = rq_pc | PC_W'(ev5 == cur);
        endcase
        res.redirect         = RD_VECTOR;
        res.vector_level     = ev;
        res.use_reset_vector = (ev < 4'd9) && rvo_ext[ev];
        st.pend[LVL_GDIS]    = 1'b1;
      end
    end

    res.current_level = active_level(st.pend);
    res.supervisor    = !in_user(st.pend);
    state_o = st;
    res_o   = res;
  end

endmodule

>>> rtl/core/core_event_priority_controller.sv
// Sixteen-level nested event controller: top level with input and result registers.
// Each accepted beat is held in the input register, evaluated, and its result registered.
// Throughput: one event per cycle while results are taken; state update runs in the cycle the input register drains.
// Input is taken while a result waits, until the input register also fills.
// Reset (async, active low): mask 0x001f, pending 0x0012, latched and return addresses
// zero, self nest off, reset vector overrides cleared.
`timescale 1ns / 1ps
module core_event_priority_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cepc_stream_if.sink                 evt_i,
  cepc_stream_if.source               res_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cepc_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import cepc_pkg::*;

  logic             snen_q;
  logic [CFG_W-1:0] rvo_q;
  state_t           state_q;
  state_t           state_d;
  logic             in_valid_q;
  evt_t             in_q;
  logic             out_valid_q;
  res_t             out_q;
  res_t             res_d;
  logic             advance;
  evt_t             evt_pl;

  assign evt_pl  = evt_i.payload;
  assign advance = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready   = !in_valid_q || advance;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  cepc_engine u_engine (
    .state_i (state_q),
    .snen_i  (snen_q),
    .rvo_i   (rvo_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snen_q <= 1'b0;
      rvo_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SELF_NEST: snen_q <= cfg_wdata_i[0];
        CFG_RESET_VEC: rvo_q  <= cfg_wdata_i & OVERRIDE_BITS;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mask  <= MASK_RESET;
      state_q.pend  <= PEND_RESET;
      state_q.latch <= '0;
      state_q.ra    <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_i.valid && evt_i.ready) in_valid_q <= 1'b1;
      else if (advance)               in_valid_q <= 1'b0;
      if (advance)          out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) in_q <= evt_pl;
    if (advance) out_q <= res_d;
  end

endmodule

>>> tb/core_event_priority_controller_test.sv
// Self-checking testbench for the core event priority controller.
`timescale 1ns / 1ps
module core_event_priority_controller_test;
  import cepc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int EMU_L  = LVL_EMU;
  localparam int RST_L  = LVL_RST;
  localparam int NMI_L  = LVL_NMI;
  localparam int EVX_L  = LVL_EVX;
  localparam int GDIS_L = LVL_GDIS;
  localparam word_t GDIS_MASK = word_t'(1) << LVL_GDIS;
  localparam word_t EMU_MASK  = word_t'(1) << LVL_EMU;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  cepc_stream_if #(.payload_t(evt_t)) evt_if ();
  cepc_stream_if #(.payload_t(res_t)) res_if ();

  core_event_priority_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // controller shadow state
  word_t            m_mask, m_pend, m_latch;
  logic [PC_W-1:0]  m_ret [NUM_RA];
  bit               m_self_nest;
  logic [CFG_W-1:0] m_rv;

  res_t awaited[$];
  res_t exp_res;

  int cycle_count = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int n_entries = 0, n_returns = 0, n_faults = 0, n_settings = 0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int tx_calm_left = 0;
  int rx_calm_left = 0;
  int rx_stall_left = 0;
  int rx_hold_left = 0;

  function automatic int ctl_lowest(input word_t w);
    for (int i = 0; i < NUM_LEVELS; i++)
      if (w[i]) return i;
    return -1;
  endfunction

  function automatic int ctl_level();
    int l;
    l = ctl_lowest(m_pend & ~GDIS_MASK);
    return (l < 0) ? NUM_LEVELS : l;
  endfunction

  function automatic bit ctl_user();
    return (m_pend & ~(EMU_MASK | GDIS_MASK)) == '0;
  endfunction

  function automatic void ctl_reset();
    m_mask      = MASK_RESET;
    m_pend      = PEND_RESET;
    m_latch     = '0;
    m_ret       = '{default: '0};
    m_self_nest = 1'b0;
    m_rv        = '0;
  endfunction

  // ev_in < 0: only look for a latched event that can now be taken
  function automatic void ctl_take(input int ev_in, input logic [PC_W-1:0] pc, inout res_t r);
    int    cur;
    int    ev;
    bit    gdis;
    bit    enter;
    word_t b;
    cur   = ctl_level();
    gdis  = m_pend[GDIS_L];
    ev    = ev_in;
    enter = 1'b0;
    if (ev < 0) begin
      if (gdis) return;
      ev = ctl_lowest(m_latch);
      if (ev < 0 || ev > cur || (!m_self_nest && ev == cur)) return;
    end
    b = word_t'(1) << ev;
    m_latch |= b;
    if (ev == EMU_L || ev == RST_L) begin
      enter = 1'b1;
    end else if (ev <= EVX_L && cur <= EVX_L && ev >= cur) begin
      r.fault = FLT_DOUBLE;
      return;
    end else if (gdis && cur != NUM_LEVELS) begin
      enter = 1'b0;
    end else if ((m_mask & b) == '0) begin
      enter = 1'b0;
    end else if (ev < cur || (m_self_nest && ev == cur)) begin
      enter = 1'b1;
    end
    if (!enter) return;
    m_pend  |= b;
    m_latch &= ~b;
    case (ev)
      EMU_L: begin
        m_ret[RA_EMU] = pc;
        r.fault = FLT_EMU;
      end
      NMI_L: m_ret[RA_NMI] = pc;
      EVX_L: m_ret[RA_EVX] = pc;
      RST_L, GDIS_L: ;
      default: m_ret[RA_INT] = pc | PC_W'(ev == cur);  // bit 0 marks a self nest
    endcase
    r.redirect         = RD_VECTOR;
    r.vector_level     = LVL_W'(ev);
    r.use_reset_vector = (ev < CFG_W) ? m_rv[ev] : 1'b0;
    m_pend |= GDIS_MASK;
  endfunction

  function automatic void ctl_priv(input logic [PC_W-1:0] pc, inout res_t r);
    r.fault = FLT_PRIV;
    ctl_take(EVX_L, pc, r);
  endfunction

  function automatic void ctl_return(input int lvl, input bit uc, input logic [PC_W-1:0] pc,
                                     inout res_t r);
    bit              emu_was;
    bit              ok;
    int              cur;
    int              ev;
    logic [1:0]      slot;
    logic [PC_W-1:0] t;
    emu_was = m_pend[EMU_L];
    m_pend[EMU_L] = 1'b0;
    if (ctl_user()) begin
      ctl_priv(pc, r);
      return;
    end
    cur = ctl_level();
    ev  = uc ? cur : lvl;
    case (ev)
      EMU_L: begin
        ok   = emu_was;
        slot = RA_EMU;
      end
      NMI_L: begin
        ok   = (cur == NMI_L);
        slot = RA_NMI;
      end
      EVX_L: begin
        ok   = (cur == EVX_L);
        slot = RA_EVX;
      end
      default: begin
        ok   = !(cur <= GDIS_L && cur != RST_L);
        slot = RA_INT;
      end
    endcase
    if (!ok) begin
      ctl_priv(pc, r);
      return;
    end
    t = m_ret[slot];
    if (t[0]) t[0] = 1'b0;
    else m_pend &= ~(word_t'(1) << ev);
    r.target_pc = t;
    r.redirect  = RD_RETURN;
    m_pend &= ~GDIS_MASK;
    ctl_take(-1, t, r);
  endfunction

  function automatic res_t ctl_respond(input evt_t e);
    res_t r;
    bit   lvl_bad;
    r = '0;
    lvl_bad = !e.use_current && int'(e.level) >= NUM_LEVELS;
    case (e.op)
      OP_RAISE: begin
        if (!lvl_bad) begin
          if (ctl_user()) ctl_priv(e.pc, r);
          else ctl_take(e.use_current ? -1 : int'(e.level), e.pc, r);
        end
      end
      OP_RETURN: begin
        if (!lvl_bad && !(!e.use_current && e.level == LVL_GDIS))
          ctl_return(int'(e.level), e.use_current, e.pc, r);
      end
      OP_MCLR: begin
        if (ctl_user()) begin
          ctl_priv(e.pc, r);
        end else begin
          r.prior_mask = m_mask;
          m_mask &= UNMASKABLE;
        end
      end
      OP_MSET: begin
        if (ctl_user()) ctl_priv(e.pc, r);
        else m_mask = (e.mask_value & ~UNMASKABLE) | (m_mask & UNMASKABLE);
      end
      OP_GEN: begin
        m_pend &= ~GDIS_MASK;
        ctl_take(-1, e.pc, r);
      end
      OP_GDIS: m_pend |= GDIS_MASK;
      default: ;
    endcase
    r.current_level = CUR_W'(ctl_level());
    r.supervisor    = !ctl_user();
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH beat %0d: %s", beats_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        note_mismatch("result beat with nothing outstanding");
      end else begin
        exp_res = awaited.pop_front();
        check_field("redirect", 32'(res_if.payload.redirect), 32'(exp_res.redirect));
        check_field("vector_level", 32'(res_if.payload.vector_level), 32'(exp_res.vector_level));
        check_field("use_reset_vector", 32'(res_if.payload.use_reset_vector),
                    32'(exp_res.use_reset_vector));
        check_field("target_pc", res_if.payload.target_pc, exp_res.target_pc);
        check_field("prior_mask", 32'(res_if.payload.prior_mask), 32'(exp_res.prior_mask));
        check_field("fault", 32'(res_if.payload.fault), 32'(exp_res.fault));
        check_field("current_level", 32'(res_if.payload.current_level),
                    32'(exp_res.current_level));
        check_field("supervisor", 32'(res_if.payload.supervisor), 32'(exp_res.supervisor));
      end
      beats_checked++;
    end
  end

  // result receiver: random stall bursts, calm stretches, and a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      res_if.ready <= 1'b0;
      rx_hold_left--;
    end else if (!rx_idle_on || rx_calm_left > 0) begin
      res_if.ready <= 1'b1;
      if (rx_calm_left > 0) rx_calm_left--;
    end else if (rx_stall_left > 0) begin
      res_if.ready <= 1'b0;
      rx_stall_left--;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 49) == 0) rx_calm_left = $urandom_range(30, 120);
      else if ($urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [PC_W-1:0] rand_pc();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic evt_t ev_of(input op_e op, input int lvl, input bit uc,
                                 input logic [15:0] mv, input logic [PC_W-1:0] pc);
    evt_t e;
    e.op          = op;
    e.level       = LVL_W'(lvl);
    e.use_current = uc;
    e.mask_value  = mv;
    e.pc          = pc;
    return e;
  endfunction

  function automatic evt_t rand_event();
    int  r;
    op_e op;
    r = $urandom_range(0, 99);
    if (r < 28) op = OP_RAISE;
    else if (r < 52) op = OP_RETURN;
    else if (r < 60) op = OP_MSET;
    else if (r < 66) op = OP_MCLR;
    else if (r < 80) op = OP_GEN;
    else if (r < 92) op = OP_GDIS;
    else op = op_e'(3'($urandom_range(6, 7)));
    return ev_of(op, $urandom_range(0, 15), 1'($urandom_range(0, 1)), 16'($urandom),
                 rand_pc());
  endfunction

  task automatic sender_gap();
    if (tx_calm_left > 0) begin
      tx_calm_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      tx_calm_left = $urandom_range(20, 60);
    end else if ($urandom_range(0, 4) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // offer one event beat, predict on acceptance
  task automatic send_event(input evt_t e);
    res_t outcome;
    evt_if.valid   <= 1'b1;
    evt_if.payload <= e;
    do @(posedge clk_i); while (evt_if.ready !== 1'b1);
    outcome = ctl_respond(e);
    awaited.push_back(outcome);
    items_sent++;
    if (outcome.redirect == RD_VECTOR) n_entries++;
    if (outcome.redirect == RD_RETURN) n_returns++;
    if (outcome.fault != FLT_NONE) n_faults++;
    if (tx_idle_on) sender_gap();
  endtask

  task automatic wait_drain();
    evt_if.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SELF_NEST) m_self_nest = val[0];
    else m_rv = val & OVERRIDE_BITS;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input bit self_nest, input logic [CFG_W-1:0] rv);
    wait_drain();
    write_reg(CFG_SELF_NEST, CFG_W'(self_nest));
    write_reg(CFG_RESET_VEC, rv);
    n_settings++;
  endtask

  // open the mask, enable, nest a few events, then unwind
  task automatic send_episode();
    int          depth;
    int          lvl;
    bit          uc;
    logic [15:0] mv;
    depth = $urandom_range(1, 4);
    mv = 16'($urandom);
    if ($urandom_range(0, 3) != 0) mv = mv | ~UNMASKABLE;
    send_event(ev_of(OP_MSET, $urandom_range(0, 15), 1'($urandom_range(0, 1)), mv,
                     rand_pc()));
    send_event(ev_of(OP_GEN, $urandom_range(0, 15), 1'($urandom_range(0, 1)), 16'($urandom),
                     rand_pc()));
    for (int k = 0; k < depth; k++) begin
      case ($urandom_range(0, 7))
        0: lvl = $urandom_range(0, GDIS_L);
        1: lvl = (ctl_level() < NUM_LEVELS) ? ctl_level() : NUM_LEVELS - 1;
        default: lvl = $urandom_range(GDIS_L + 1, NUM_LEVELS - 1);
      endcase
      send_event(ev_of(OP_RAISE, lvl, $urandom_range(0, 7) == 0, 16'($urandom), rand_pc()));
      if ($urandom_range(0, 1) == 1)
        send_event(ev_of(OP_GEN, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                         16'($urandom), rand_pc()));
    end
    for (int k = 0; k <= depth; k++) begin
      lvl = ctl_level();
      if (lvl >= NUM_LEVELS) lvl = $urandom_range(0, 15);
      uc = $urandom_range(0, 2) != 0;
      if (!uc && $urandom_range(0, 7) == 0) lvl = $urandom_range(0, 15);
      send_event(ev_of(OP_RETURN, lvl, uc, 16'($urandom), rand_pc()));
    end
  endtask

  task automatic random_block(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) send_episode();
      else send_event(rand_event());
    end
  endtask

  task automatic test_directed();
    send_event(ev_of(OP_RAISE, 5, 1'b0, 16'h0000, 32'h0000_0000));   // latched under reset
    send_event(ev_of(OP_RETURN, 0, 1'b1, 16'hffff, 32'hffff_ffff));  // leave reset level
    send_event(ev_of(op_e'(3'd6), 15, 1'b1, 16'hffff, 32'h1234_5679));
    send_event(ev_of(op_e'(3'd7), 0, 1'b0, 16'h0000, 32'h0000_0000));
    send_event(ev_of(OP_MCLR, 0, 1'b0, 16'h0000, 32'h8000_0001));    // user mode: privilege
    send_event(ev_of(OP_RAISE, EVX_L, 1'b0, 16'h0000, 32'h0000_0100)); // double fault
    send_event(ev_of(OP_MSET, 0, 1'b0, 16'hffff, 32'h0000_0200));
    send_event(ev_of(OP_MCLR, 0, 1'b0, 16'h0000, 32'h0000_0300));    // old mask all ones
    send_event(ev_of(OP_MSET, 0, 1'b0, 16'hffe0, 32'h0000_0400));
    send_event(ev_of(OP_GEN, 0, 1'b0, 16'h0000, 32'h0000_0500));
    send_event(ev_of(OP_RAISE, NMI_L, 1'b0, 16'h0000, 32'hffff_ffff));
    send_event(ev_of(OP_RETURN, EVX_L, 1'b0, 16'h0000, 32'h0000_0600)); // not at that level
    send_event(ev_of(OP_RETURN, NMI_L, 1'b0, 16'h0000, 32'h0000_0700));
    send_event(ev_of(OP_RAISE, EMU_L, 1'b0, 16'h0000, 32'h0000_0000));
    send_event(ev_of(OP_RETURN, EMU_L, 1'b0, 16'h0000, 32'h0000_0800));
    send_event(ev_of(OP_RETURN, EMU_L, 1'b0, 16'h0000, 32'h0000_0900)); // emulation not active
    send_event(ev_of(OP_RAISE, GDIS_L, 1'b0, 16'h0000, 32'h0000_0a00));
    send_event(ev_of(OP_RETURN, GDIS_L, 1'b0, 16'h0000, 32'h0000_0b00)); // ignored
    send_event(ev_of(OP_GDIS, 0, 1'b0, 16'h0000, 32'h0000_0c00));
    send_event(ev_of(OP_GEN, 0, 1'b0, 16'h0000, 32'h0000_0d00));
    send_event(ev_of(OP_RAISE, 0, 1'b1, 16'h0000, 32'h0000_0e00));
    send_event(ev_of(OP_RAISE, 15, 1'b0, 16'h0000, 32'h0000_0f01));
    send_event(ev_of(OP_RAISE, RST_L, 1'b0, 16'h0000, 32'h0000_1000));
    send_event(ev_of(OP_RETURN, 0, 1'b1, 16'h0000, 32'h0000_1100));
    send_event(ev_of(OP_RETURN, 0, 1'b1, 16'h0000, 32'h0000_1200));
    send_event(ev_of(OP_RETURN, 0, 1'b1, 16'h0000, 32'h0000_1300));
    wait_drain();
  endtask

  task automatic test_config_sweep();
    apply_config(1'b0, '0);
    random_block(230);
    apply_config(1'b1, OVERRIDE_BITS);
    random_block(230);
    apply_config(1'b0, OVERRIDE_BITS);
    random_block(230);
    apply_config(1'b1, CFG_W'($urandom_range(0, 511)));
    random_block(230);
    apply_config(1'b1, '0);
    random_block(230);
    apply_config(1'b0, CFG_W'($urandom_range(0, 511)));
    random_block(230);
  endtask

  // receiver holds off while the sender keeps offering, then the sender drains
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_left = 300;
    for (int k = 0; k < 24; k++) send_event(rand_event());
    wait_drain();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_full_rate();
    apply_config(1'b1, CFG_W'($urandom_range(0, 511)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_block(250);
  endtask

  initial begin
    evt_if.valid   <= 1'b0;
    evt_if.payload <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_SELF_NEST;
    cfg_wdata_i    <= '0;
    rst_ni         <= 1'b0;
    ctl_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_full_rate();

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d events over %0d register settings: %0d vector entries, %0d returns",
             items_sent, n_settings, n_entries, n_returns);
    $display("Faults reported %0d, result beats checked %0d, mismatches %0d",
             n_faults, beats_checked, mismatches);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> core_event_priority_controller.f
rtl/core/cepc_pkg.sv
rtl/core/cepc_stream_if.sv
rtl/core/cepc_engine.sv
rtl/core/core_event_priority_controller.sv
tb/core_event_priority_controller_test.sv
